@@ design/vector2d_alu_unit_macros.svh @@
// Assertion helpers for the vector unit checker.
// Both expect a signal named clk, and VA_ASSERT also rst_n, in the calling scope.
`ifndef VECTOR2D_ALU_UNIT_MACROS_SVH
`define VECTOR2D_ALU_UNIT_MACROS_SVH

// Checked only outside reset.
`define VA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vector unit check failed");

// Checked on every edge, reset included.
`define VA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vector unit check failed");

`endif

@@ design/va_pkg.sv @@
`timescale 1ns / 1ps

package va_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FUNC_W          = 3;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SUB    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SCALE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LENGTH = 3'd3;
    localparam logic [FUNC_W-1:0] FN_NORM   = 3'd4;

    // Per-item control travelling down the pipeline
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ov;
        logic              neg_x;
        logic              neg_y;
    } va_ctrl_t;

endpackage

@@ design/va_front.sv @@
`timescale 1ns / 1ps

// Three stages: partial products and add/sub, product sums, scale rounding
// and sum of squares.
module va_front #(
    parameter int W = va_pkg::COORD_WIDTH_DEF,
    parameter int F = va_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [va_pkg::FUNC_W-1:0] func,
    input  logic [W-1:0]              ax,
    input  logic [W-1:0]              ay,
    input  logic [W-1:0]              bx,
    input  logic [W-1:0]              by,
    input  logic [W-1:0]              scalar,
    output logic                      out_valid,
    output va_pkg::va_ctrl_t          out_ctrl,
    output logic [W-1:0]              out_rx,
    output logic [W-1:0]              out_ry,
    output logic [W-1:0]              out_mx,
    output logic [W-1:0]              out_my,
    output logic [2*W-1:0]            out_s
);

    localparam int H  = (W + 1) / 2;
    localparam int PW = 4 * H;

    logic [W-1:0]   a_in [2];
    logic [W-1:0]   b_in [2];
    logic [W-1:0]   mag_a [2];
    logic [W-1:0]   mag_sc;
    logic [2*H-1:0] opa [4];
    logic [2*H-1:0] opb [4];
    logic [2*H-1:0] pp_next [4][4];
    logic [W:0]     as_sum [2];
    logic [W-1:0]   as_next [2];
    logic           as_ov_next;

    logic                      v1_reg;
    logic [va_pkg::FUNC_W-1:0] func1_reg;
    logic                      neg_a1_reg [2];
    logic                      neg_s1_reg [2];
    logic [W-1:0]              mag1_reg [2];
    logic [W-1:0]              as1_reg [2];
    logic                      as_ov1_reg;
    logic [2*H-1:0]            pp1_reg [4][4];

    logic [PW-1:0]             prod_next [4];
    logic                      v2_reg;
    logic [va_pkg::FUNC_W-1:0] func2_reg;
    logic                      neg_a2_reg [2];
    logic                      neg_s2_reg [2];
    logic [W-1:0]              mag2_reg [2];
    logic [W-1:0]              as2_reg [2];
    logic                      as_ov2_reg;
    logic [PW-1:0]             prod2_reg [4];

    logic [PW:0]      sc_h [2];
    logic [PW:0]      sc_lim [2];
    logic [PW:0]      sc_val [2];
    logic [W-1:0]     sc_res [2];
    logic             sc_ov;
    logic [W-1:0]     r_next [2];
    logic             ov_next;
    va_pkg::va_ctrl_t ctrl_next;
    logic [2*W-1:0]   s_next;

    logic             v3_reg;
    va_pkg::va_ctrl_t ctrl3_reg;
    logic [W-1:0]     r3_reg [2];
    logic [W-1:0]     mag3_reg [2];
    logic [2*W-1:0]   s3_reg;

    assign a_in[0] = ax;
    assign a_in[1] = ay;
    assign b_in[0] = bx;
    assign b_in[1] = by;

    // Stage 1: magnitudes, add/sub with saturation, partial products
    always_comb
    begin
        mag_sc     = scalar[W-1] ? (~scalar + W'(1)) : scalar;
        as_ov_next = 1'b0;
        for (int l = 0; l < 2; l++)
        begin
            mag_a[l] = a_in[l][W-1] ? (~a_in[l] + W'(1)) : a_in[l];
            if (func == va_pkg::FN_SUB)
            begin
                as_sum[l] = {a_in[l][W-1], a_in[l]} - {b_in[l][W-1], b_in[l]};
            end
            else
            begin
                as_sum[l] = {a_in[l][W-1], a_in[l]} + {b_in[l][W-1], b_in[l]};
            end
            if (as_sum[l][W] != as_sum[l][W-1])
            begin
                as_ov_next = 1'b1;
                as_next[l] = as_sum[l][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                as_next[l] = as_sum[l][W-1:0];
            end
        end
        opa[0] = (2*H)'(mag_a[0]);
        opb[0] = (2*H)'(mag_sc);
        opa[1] = (2*H)'(mag_a[1]);
        opb[1] = (2*H)'(mag_sc);
        opa[2] = (2*H)'(mag_a[0]);
        opb[2] = (2*H)'(mag_a[0]);
        opa[3] = (2*H)'(mag_a[1]);
        opb[3] = (2*H)'(mag_a[1]);
        for (int u = 0; u < 4; u++)
        begin
            pp_next[u][0] = {{H{1'b0}}, opa[u][H-1:0]} * {{H{1'b0}}, opb[u][H-1:0]};
            pp_next[u][1] = {{H{1'b0}}, opa[u][H-1:0]} * {{H{1'b0}}, opb[u][2*H-1:H]};
            pp_next[u][2] = {{H{1'b0}}, opa[u][2*H-1:H]} * {{H{1'b0}}, opb[u][H-1:0]};
            pp_next[u][3] = {{H{1'b0}}, opa[u][2*H-1:H]} * {{H{1'b0}}, opb[u][2*H-1:H]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg  <= func;
            as_ov1_reg <= as_ov_next;
            for (int l = 0; l < 2; l++)
            begin
                neg_a1_reg[l] <= a_in[l][W-1];
                neg_s1_reg[l] <= a_in[l][W-1] ^ scalar[W-1];
                mag1_reg[l]   <= mag_a[l];
                as1_reg[l]    <= as_next[l];
            end
            for (int u = 0; u < 4; u++)
            begin
                for (int p = 0; p < 4; p++)
                begin
                    pp1_reg[u][p] <= pp_next[u][p];
                end
            end
        end
    end

    // Stage 2: assemble full products
    always_comb
    begin
        for (int u = 0; u < 4; u++)
        begin
            prod_next[u] = (PW'(pp1_reg[u][3]) << (2 * H))
                         + ((PW'(pp1_reg[u][1]) + PW'(pp1_reg[u][2])) << H)
                         + PW'(pp1_reg[u][0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func2_reg  <= func1_reg;
            as_ov2_reg <= as_ov1_reg;
            for (int l = 0; l < 2; l++)
            begin
                neg_a2_reg[l] <= neg_a1_reg[l];
                neg_s2_reg[l] <= neg_s1_reg[l];
                mag2_reg[l]   <= mag1_reg[l];
                as2_reg[l]    <= as1_reg[l];
            end
            for (int u = 0; u < 4; u++)
            begin
                prod2_reg[u] <= prod_next[u];
            end
        end
    end

    // Stage 3: scale rounding (ties away from zero), saturation, sum of squares
    always_comb
    begin
        sc_ov  = 1'b0;
        s_next = (2*W)'(prod2_reg[2] + prod2_reg[3]);
        for (int l = 0; l < 2; l++)
        begin
            sc_h[l]   = ((PW+1)'(prod2_reg[l]) + ((PW+1)'(1) << (F - 1))) >> F;
            sc_lim[l] = ((PW+1)'(1) << (W - 1)) - (PW+1)'(!neg_s2_reg[l]);
            if (sc_h[l] > sc_lim[l])
            begin
                sc_ov     = 1'b1;
                sc_val[l] = sc_lim[l];
            end
            else
            begin
                sc_val[l] = sc_h[l];
            end
            sc_res[l] = neg_s2_reg[l] ? W'((PW+1)'(0) - sc_val[l]) : W'(sc_val[l]);
        end
        case (func2_reg) inside
            va_pkg::FN_ADD, va_pkg::FN_SUB:
            begin
                r_next[0] = as2_reg[0];
                r_next[1] = as2_reg[1];
                ov_next   = as_ov2_reg;
            end
            va_pkg::FN_SCALE:
            begin
                r_next[0] = sc_res[0];
                r_next[1] = sc_res[1];
                ov_next   = sc_ov;
            end
            default:
            begin
                r_next[0] = '0;
                r_next[1] = '0;
                ov_next   = 1'b0;
            end
        endcase
        ctrl_next.func  = func2_reg;
        ctrl_next.ov    = ov_next;
        ctrl_next.neg_x = neg_a2_reg[0];
        ctrl_next.neg_y = neg_a2_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl3_reg <= ctrl_next;
            s3_reg    <= s_next;
            for (int l = 0; l < 2; l++)
            begin
                r3_reg[l]   <= r_next[l];
                mag3_reg[l] <= mag2_reg[l];
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_ctrl  = ctrl3_reg;
    assign out_rx    = r3_reg[0];
    assign out_ry    = r3_reg[1];
    assign out_mx    = mag3_reg[0];
    assign out_my    = mag3_reg[1];
    assign out_s     = s3_reg;

endmodule

@@ design/va_sqrt.sv @@
`timescale 1ns / 1ps

// Digit-by-digit square root, one root bit per stage, W stages.
// Leaves the truncated root and the remainder s - root^2.
module va_sqrt #(
    parameter int W   = va_pkg::COORD_WIDTH_DEF,
    parameter int SBW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [2*W-1:0] in_s,
    input  logic [SBW-1:0] in_sb,
    output logic           out_valid,
    output logic [W-1:0]   out_root,
    output logic [2*W-1:0] out_rem,
    output logic [SBW-1:0] out_sb
);

    logic [W-1:0]   v_reg;
    logic [W-1:0]   root_reg [W];
    logic [2*W-1:0] rem_reg [W];
    logic [SBW-1:0] sb_reg [W];

    for (genvar g = 0; g < W; g++)
    begin : g_stage
        localparam int I = W - 1 - g;

        logic           v_in;
        logic [W-1:0]   root_in;
        logic [2*W-1:0] rem_in;
        logic [SBW-1:0] sb_in;
        logic [2*W:0]   trial;
        logic [W-1:0]   root_next;
        logic [2*W-1:0] rem_next;

        if (g == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign root_in = '0;
            assign rem_in  = in_s;
            assign sb_in   = in_sb;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign sb_in   = sb_reg[g-1];
        end

        // Try setting root bit I: (r + 2^I)^2 - r^2 = r*2^(I+1) + 2^(2I)
        always_comb
        begin
            trial = ((2*W+1)'(root_in) << (I + 1)) + ((2*W+1)'(1) << (2 * I));
            if ({1'b0, rem_in} >= trial)
            begin
                rem_next  = rem_in - (2*W)'(trial);
                root_next = root_in | (W'(1) << I);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[g] <= root_next;
                rem_reg[g]  <= rem_next;
                sb_reg[g]   <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[W-1];
    assign out_root  = root_reg[W-1];
    assign out_rem   = rem_reg[W-1];
    assign out_sb    = sb_reg[W-1];

endmodule

@@ design/va_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, two lanes sharing one divisor: m * 2^F / len with
// m <= len, one quotient bit per stage, F+1 stages.
module va_div #(
    parameter int W   = va_pkg::COORD_WIDTH_DEF,
    parameter int F   = va_pkg::FRAC_BITS_DEF,
    parameter int SBW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [W-1:0]   in_len,
    input  logic [W-1:0]   in_mx,
    input  logic [W-1:0]   in_my,
    input  logic [SBW-1:0] in_sb,
    output logic           out_valid,
    output logic [W-1:0]   out_len,
    output logic [F:0]     out_qx,
    output logic [F:0]     out_qy,
    output logic [W-1:0]   out_remx,
    output logic [W-1:0]   out_remy,
    output logic [SBW-1:0] out_sb
);

    localparam int NS = F + 1;

    logic [NS-1:0]  v_reg;
    logic [W-1:0]   len_reg [NS];
    logic [W-1:0]   r_reg [NS][2];
    logic [F:0]     q_reg [NS][2];
    logic [SBW-1:0] sb_reg [NS];
    logic [W-1:0]   m_in [2];

    assign m_in[0] = in_mx;
    assign m_in[1] = in_my;

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        logic           v_in;
        logic [W-1:0]   len_in;
        logic [SBW-1:0] sb_in;
        logic [W:0]     r_in [2];
        logic [F:0]     q_in [2];
        logic [W-1:0]   r_next [2];
        logic [F:0]     q_next [2];

        if (g == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign len_in = in_len;
            assign sb_in  = in_sb;
            for (genvar l = 0; l < 2; l++)
            begin : g_lane
                assign r_in[l] = {1'b0, m_in[l]};
                assign q_in[l] = '0;
            end
        end
        else
        begin : g_rest
            assign v_in   = v_reg[g-1];
            assign len_in = len_reg[g-1];
            assign sb_in  = sb_reg[g-1];
            for (genvar l = 0; l < 2; l++)
            begin : g_lane
                assign r_in[l] = {r_reg[g-1][l], 1'b0};
                assign q_in[l] = q_reg[g-1][l];
            end
        end

        // One quotient bit per lane
        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                if (r_in[l] >= {1'b0, len_in})
                begin
                    r_next[l] = W'(r_in[l] - {1'b0, len_in});
                    q_next[l] = {q_in[l][F-1:0], 1'b1};
                end
                else
                begin
                    r_next[l] = W'(r_in[l]);
                    q_next[l] = {q_in[l][F-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                len_reg[g] <= len_in;
                sb_reg[g]  <= sb_in;
                for (int l = 0; l < 2; l++)
                begin
                    r_reg[g][l] <= r_next[l];
                    q_reg[g][l] <= q_next[l];
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_len   = len_reg[NS-1];
    assign out_qx    = q_reg[NS-1][0];
    assign out_qy    = q_reg[NS-1][1];
    assign out_remx  = r_reg[NS-1][0];
    assign out_remy  = r_reg[NS-1][1];
    assign out_sb    = sb_reg[NS-1];

endmodule

@@ design/vector2d_alu_unit.sv @@
// Pipeline: 3 front stages, one stage per root bit, one length rounding stage, one
// stage per quotient bit, one output stage. Throughput: one item per cycle when not
// stalled; every operation takes the same path, so results leave in order.
// A stall holds every stage in place.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps

module vector2d_alu_unit #(
    parameter int FRAC_BITS   = va_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = va_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [va_pkg::FUNC_W-1:0]     func,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] scalar,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] rx,
    output logic signed [COORD_WIDTH-1:0] ry,
    output logic [COORD_WIDTH-2:0]        magnitude,
    output logic                          overflow,
    output logic                          zero_vector
);

    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int CW   = $bits(va_pkg::va_ctrl_t);
    localparam int SB1W = CW + 4 * W;
    localparam int SB2W = CW + 2 * W;
    localparam int QW   = F + 2;
    localparam int MW   = ((QW > W) ? QW : W) + 1;

    logic en;

    // Front
    logic             f_valid;
    va_pkg::va_ctrl_t f_ctrl;
    logic [W-1:0]     f_rx;
    logic [W-1:0]     f_ry;
    logic [W-1:0]     f_mx;
    logic [W-1:0]     f_my;
    logic [2*W-1:0]   f_s;

    // Square root
    logic             q_valid;
    logic [W-1:0]     q_root;
    logic [2*W-1:0]   q_rem;
    logic [SB1W-1:0]  q_sb;
    va_pkg::va_ctrl_t q_ctrl;
    logic [W-1:0]     q_rx;
    logic [W-1:0]     q_ry;
    logic [W-1:0]     q_mx;
    logic [W-1:0]     q_my;

    // Length rounding stage
    logic             l_valid_reg;
    va_pkg::va_ctrl_t l_ctrl_reg;
    logic [W-1:0]     l_rx_reg;
    logic [W-1:0]     l_ry_reg;
    logic [W-1:0]     l_mx_reg;
    logic [W-1:0]     l_my_reg;
    logic [W-1:0]     l_len_reg;
    logic [W-1:0]     l_len_next;

    // Divider
    logic             d_valid;
    logic [W-1:0]     d_len;
    logic [F:0]       d_q [2];
    logic [W-1:0]     d_rem [2];
    logic [SB2W-1:0]  d_sb;
    va_pkg::va_ctrl_t d_ctrl;
    logic [W-1:0]     d_rx;
    logic [W-1:0]     d_ry;

    // Output stage
    logic [QW-1:0]    n_q [2];
    logic [MW-1:0]    n_lim [2];
    logic [MW-1:0]    n_val [2];
    logic [W-1:0]     n_res [2];
    logic             n_ov;
    logic             n_neg [2];
    logic             out_valid_reg;
    logic [W-1:0]     rx_reg;
    logic [W-1:0]     ry_reg;
    logic [W-2:0]     mag_reg;
    logic             ov_reg;
    logic             zv_reg;
    logic [W-1:0]     rx_next;
    logic [W-1:0]     ry_next;
    logic [W-2:0]     mag_next;
    logic             ov_next;
    logic             zv_next;

    // Whole pipeline moves unless a finished item is held at the output
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    va_front #(
        .W (W),
        .F (F)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .func      (func),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by        (by),
        .scalar    (scalar),
        .out_valid (f_valid),
        .out_ctrl  (f_ctrl),
        .out_rx    (f_rx),
        .out_ry    (f_ry),
        .out_mx    (f_mx),
        .out_my    (f_my),
        .out_s     (f_s)
    );

    va_sqrt #(
        .W   (W),
        .SBW (SB1W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_s      (f_s),
        .in_sb     ({f_ctrl, f_rx, f_ry, f_mx, f_my}),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_rem   (q_rem),
        .out_sb    (q_sb)
    );

    assign {q_ctrl, q_rx, q_ry, q_mx, q_my} = q_sb;

    // Round the root to nearest: up when the remainder exceeds the root
    assign l_len_next = q_root + W'(q_rem > (2*W)'(q_root));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            l_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_ctrl_reg <= q_ctrl;
            l_rx_reg   <= q_rx;
            l_ry_reg   <= q_ry;
            l_mx_reg   <= q_mx;
            l_my_reg   <= q_my;
            l_len_reg  <= l_len_next;
        end
    end

    va_div #(
        .W   (W),
        .F   (F),
        .SBW (SB2W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (l_valid_reg),
        .in_len    (l_len_reg),
        .in_mx     (l_mx_reg),
        .in_my     (l_my_reg),
        .in_sb     ({l_ctrl_reg, l_rx_reg, l_ry_reg}),
        .out_valid (d_valid),
        .out_len   (d_len),
        .out_qx    (d_q[0]),
        .out_qy    (d_q[1]),
        .out_remx  (d_rem[0]),
        .out_remy  (d_rem[1]),
        .out_sb    (d_sb)
    );

    assign {d_ctrl, d_rx, d_ry} = d_sb;
    assign n_neg[0] = d_ctrl.neg_x;
    assign n_neg[1] = d_ctrl.neg_y;

    // Normalize: round quotient (ties away from zero), then saturate and sign
    always_comb
    begin
        n_ov = 1'b0;
        for (int l = 0; l < 2; l++)
        begin
            n_q[l]   = QW'(d_q[l]) + QW'({d_rem[l], 1'b0} >= {1'b0, d_len});
            n_lim[l] = (MW'(1) << (W - 1)) - MW'(!n_neg[l]);
            if (MW'(n_q[l]) > n_lim[l])
            begin
                n_ov     = 1'b1;
                n_val[l] = n_lim[l];
            end
            else
            begin
                n_val[l] = MW'(n_q[l]);
            end
            n_res[l] = n_neg[l] ? W'(MW'(0) - n_val[l]) : W'(n_val[l]);
        end
    end

    // Result select
    always_comb
    begin
        rx_next  = '0;
        ry_next  = '0;
        mag_next = '0;
        ov_next  = 1'b0;
        zv_next  = 1'b0;
        unique case (d_ctrl.func) inside
            va_pkg::FN_ADD, va_pkg::FN_SUB, va_pkg::FN_SCALE:
            begin
                rx_next = d_rx;
                ry_next = d_ry;
                ov_next = d_ctrl.ov;
            end
            va_pkg::FN_LENGTH:
            begin
                mag_next = d_len[W-1] ? {(W-1){1'b1}} : d_len[W-2:0];
                ov_next  = d_len[W-1];
            end
            va_pkg::FN_NORM:
            begin
                if (d_len == '0)
                begin
                    zv_next = 1'b1;
                end
                else
                begin
                    rx_next = n_res[0];
                    ry_next = n_res[1];
                    ov_next = n_ov;
                end
            end
            default:
            begin
                rx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            mag_reg <= mag_next;
            ov_reg  <= ov_next;
            zv_reg  <= zv_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rx          = rx_reg;
    assign ry          = ry_reg;
    assign magnitude   = mag_reg;
    assign overflow    = ov_reg;
    assign zero_vector = zv_reg;

endmodule

@@ design/va_checker.sv @@
`timescale 1ns / 1ps
`include "vector2d_alu_unit_macros.svh"

// Port-level checks on the vector unit
module va_checker #(
    parameter int COORD_WIDTH = va_pkg::COORD_WIDTH_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [COORD_WIDTH-1:0] rx,
    input logic [COORD_WIDTH-2:0] magnitude,
    input logic [COORD_WIDTH-1:0] ry,
    input logic                   overflow,
    input logic                   zero_vector
);

    logic [3*COORD_WIDTH:0] result_bits;

    assign result_bits = {rx, ry, magnitude, overflow, zero_vector};

    // A held result stays put
    `VA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
    `VA_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(result_bits))

    // With nothing waiting at the output, input is always taken
    `VA_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready)

    // A zero vector result carries nothing else
    `VA_ASSERT(a_zero_vec, out_valid && zero_vector |-> {rx, ry, magnitude, overflow} == '0)

    // Only a length result has a magnitude, and it has no vector
    `VA_ASSERT(a_mag_only, out_valid && magnitude != '0 |-> rx == '0 && ry == '0 && !zero_vector)

endmodule

bind vector2d_alu_unit va_checker #(.COORD_WIDTH(COORD_WIDTH)) u_va_checker (.*);
